>>> rtl/eglqr_pkg.sv
// Shared types and constants for the event-gated state-feedback controller.
package eglqr_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN_POSITION      = 3'd0,
    REG_GAIN_VELOCITY      = 3'd1,
    REG_GAIN_ANGLE         = 3'd2,
    REG_GAIN_ANGULAR_RATE  = 3'd3,
    REG_RATIO_THRESHOLD    = 3'd4,
    REG_ANGLE_DEAD_BAND    = 3'd5,
    REG_POSITION_DEAD_BAND = 3'd6
  } reg_idx_t;

  // Gate outcome carried with every result beat
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ANGLE    = 2'd1,
    EV_POSITION = 2'd2
  } gate_ev_t;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned BAND_W = 15;
  localparam int unsigned MAG_W  = 17;
  localparam int unsigned IDX_W  = 3;

  localparam logic signed [DATA_W-1:0] GAIN_POSITION_RST     = -16'sd256;
  localparam logic signed [DATA_W-1:0] GAIN_VELOCITY_RST     = -16'sd1045;
  localparam logic signed [DATA_W-1:0] GAIN_ANGLE_RST        = 16'sd2602;
  localparam logic signed [DATA_W-1:0] GAIN_ANGULAR_RATE_RST = 16'sd418;
  localparam logic [DATA_W-1:0]        RATIO_THRESHOLD_RST   = 16'd17203;
  localparam logic [DATA_W-1:0]        LAST_MAG_RST          = 16'd1;

  // Unity in Q1.14, the command clip limit
  localparam logic signed [DATA_W-1:0] CMD_LIMIT = 16'sd16384;

endpackage

>>> rtl/eglqr_gate.sv
// Dead-band check and log-ratio event test for one gated magnitude.
module eglqr_gate (
  input  logic [eglqr_pkg::MAG_W-1:0]  mag,
  input  logic [eglqr_pkg::DATA_W-1:0] last_mag,
  input  logic [eglqr_pkg::DATA_W-1:0] ratio,
  input  logic [eglqr_pkg::BAND_W-1:0] dead_band,
  output logic                         active,
  output logic                         fire
);
  import eglqr_pkg::*;

  localparam int unsigned PROD_W = 33;
  localparam int unsigned FRAC_W = 14;

  logic [PROD_W-1:0] cur_scaled;
  logic [PROD_W-1:0] last_scaled;
  logic [PROD_W-1:0] cur_ratio;
  logic [PROD_W-1:0] last_ratio;

  assign active      = mag > MAG_W'(dead_band);
  // cross-multiply so no division is needed
  assign cur_scaled  = PROD_W'(mag) << FRAC_W;
  assign last_scaled = PROD_W'(last_mag) << FRAC_W;
  assign cur_ratio   = PROD_W'(ratio) * PROD_W'(mag);
  assign last_ratio  = PROD_W'(ratio) * PROD_W'(last_mag);
  assign fire        = (cur_scaled >= last_ratio) || (last_scaled >= cur_ratio);

endmodule

>>> rtl/eglqr_cmd.sv
// Feedback law: negated gain-weighted state sum, rounded to Q1.14 and clipped.
module eglqr_cmd (
  input  logic signed [eglqr_pkg::DATA_W-1:0] gain_position,
  input  logic signed [eglqr_pkg::DATA_W-1:0] gain_velocity,
  input  logic signed [eglqr_pkg::DATA_W-1:0] gain_angle,
  input  logic signed [eglqr_pkg::DATA_W-1:0] gain_angular_rate,
  input  logic signed [eglqr_pkg::DATA_W-1:0] pos_err,
  input  logic signed [eglqr_pkg::DATA_W-1:0] velocity,
  input  logic signed [eglqr_pkg::DATA_W-1:0] angle,
  input  logic signed [eglqr_pkg::DATA_W-1:0] angular_rate,
  output logic signed [eglqr_pkg::DATA_W-1:0] command
);
  import eglqr_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned ACC_W  = PROD_W + 4;
  localparam int unsigned SHIFT  = 4;

  logic signed [PROD_W-1:0] p_pos;
  logic signed [PROD_W-1:0] p_vel;
  logic signed [PROD_W-1:0] p_ang;
  logic signed [PROD_W-1:0] p_rate;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  biased;
  logic signed [ACC_W-1:0]  q;

  assign p_pos  = gain_position * pos_err;
  assign p_vel  = gain_velocity * velocity;
  assign p_ang  = gain_angle * angle;
  assign p_rate = gain_angular_rate * angular_rate;

  assign sum    = ACC_W'(p_pos) + ACC_W'(p_vel) + ACC_W'(p_ang) + ACC_W'(p_rate);
  // negate, add half an output LSB, floor to Q1.14
  assign biased = -sum + ACC_W'(signed'(8));
  assign q      = biased >>> SHIFT;

  always_comb begin
    if (q > ACC_W'(CMD_LIMIT)) begin
      command = CMD_LIMIT;
    end else if (q < -ACC_W'(CMD_LIMIT)) begin
      command = -CMD_LIMIT;
    end else begin
      command = DATA_W'(q);
    end
  end

endmodule

>>> rtl/event_gated_lqr_controller.sv
// Top level of the event-gated state-feedback (LQR) controller.
//
//   channel | direction | handshake          | beat contents
//   --------+-----------+--------------------+------------------------------------------
//   in_     | in        | in_valid/in_ready  | position, velocity, angle, rate, target
//   out_    | out       | out_valid/out_ready| command (Q1.14), gate_event
//   cfg_    | in        | cfg_we only        | cfg_index selects register, cfg_data
//
// One beat in per cycle and one beat out per cycle when the sink keeps up.
// Each item passes the input register, then gate plus feedback law into the
// result register. The stored magnitudes and held command update as the item
// moves into the result register, so the next item already sees them.
// A stalled result holds both stages; the input stage still fills if empty.
// Reset is synchronous: gains and bands to defaults, magnitudes to one LSB,
// held command to zero.
module event_gated_lqr_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [eglqr_pkg::DATA_W-1:0]  in_position,
  input  logic signed [eglqr_pkg::DATA_W-1:0]  in_velocity,
  input  logic signed [eglqr_pkg::DATA_W-1:0]  in_angle,
  input  logic signed [eglqr_pkg::DATA_W-1:0]  in_angular_rate,
  input  logic signed [eglqr_pkg::DATA_W-1:0]  in_target_position,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [eglqr_pkg::DATA_W-1:0]  out_command,
  output logic [1:0]                           out_gate_event,
  // configuration port
  input  logic                                 cfg_we,
  input  logic [eglqr_pkg::IDX_W-1:0]          cfg_index,
  input  logic [eglqr_pkg::DATA_W-1:0]         cfg_data
);
  import eglqr_pkg::*;

  // Configuration registers
  logic signed [DATA_W-1:0] gain_position_r;
  logic signed [DATA_W-1:0] gain_velocity_r;
  logic signed [DATA_W-1:0] gain_angle_r;
  logic signed [DATA_W-1:0] gain_angular_rate_r;
  logic [DATA_W-1:0]        ratio_threshold_r;
  logic [BAND_W-1:0]        angle_dead_band_r;
  logic [BAND_W-1:0]        position_dead_band_r;

  // Controller state
  logic [DATA_W-1:0]        angle_last_mag_r;
  logic [DATA_W-1:0]        position_last_mag_r;
  logic signed [DATA_W-1:0] held_cmd_r;

  // Input stage
  logic                     s1_valid_r;
  logic signed [DATA_W-1:0] s1_position_r;
  logic signed [DATA_W-1:0] s1_velocity_r;
  logic signed [DATA_W-1:0] s1_angle_r;
  logic signed [DATA_W-1:0] s1_angular_rate_r;
  logic signed [DATA_W-1:0] s1_target_r;

  // Result stage
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_command_r;
  gate_ev_t                 out_event_r;

  logic                     advance;
  logic                     s1_move;
  logic signed [MAG_W-1:0]  angle_ext;
  logic signed [MAG_W-1:0]  err_wide;
  logic signed [DATA_W-1:0] pos_err;
  logic signed [MAG_W-1:0]  err_ext;
  logic [MAG_W-1:0]         angle_mag;
  logic [MAG_W-1:0]         pos_mag;
  logic                     angle_active;
  logic                     angle_fire;
  logic                     pos_active;
  logic                     pos_fire;
  gate_ev_t                 gate_nxt;
  logic signed [DATA_W-1:0] cmd_new;
  logic signed [DATA_W-1:0] cmd_nxt;

  // Handshake: the result register frees when empty or taken this cycle
  assign advance  = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  // Saturate the position error to the 16-bit range
  assign err_wide = MAG_W'(s1_position_r) - MAG_W'(s1_target_r);
  always_comb begin
    if (err_wide[MAG_W-1] != err_wide[MAG_W-2]) begin
      pos_err = err_wide[MAG_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      pos_err = err_wide[DATA_W-1:0];
    end
  end

  // Magnitudes need one extra bit to hold 32768
  assign angle_ext = MAG_W'(s1_angle_r);
  assign err_ext   = MAG_W'(pos_err);
  assign angle_mag = angle_ext[MAG_W-1] ? MAG_W'(-angle_ext) : MAG_W'(angle_ext);
  assign pos_mag   = err_ext[MAG_W-1] ? MAG_W'(-err_ext) : MAG_W'(err_ext);

  eglqr_gate u_angle_gate (
    .mag       (angle_mag),
    .last_mag  (angle_last_mag_r),
    .ratio     (ratio_threshold_r),
    .dead_band (angle_dead_band_r),
    .active    (angle_active),
    .fire      (angle_fire)
  );

  eglqr_gate u_pos_gate (
    .mag       (pos_mag),
    .last_mag  (position_last_mag_r),
    .ratio     (ratio_threshold_r),
    .dead_band (position_dead_band_r),
    .active    (pos_active),
    .fire      (pos_fire)
  );

  eglqr_cmd u_cmd (
    .gain_position     (gain_position_r),
    .gain_velocity     (gain_velocity_r),
    .gain_angle        (gain_angle_r),
    .gain_angular_rate (gain_angular_rate_r),
    .pos_err           (pos_err),
    .velocity          (s1_velocity_r),
    .angle             (s1_angle_r),
    .angular_rate      (s1_angular_rate_r),
    .command           (cmd_new)
  );

  // Angle gate wins; position gate only when the angle sits in its dead band.
  // An angle outside its band that fails the ratio test blocks the position gate.
  always_comb begin
    gate_nxt = EV_NONE;
    priority if (angle_active) begin
      if (angle_fire) begin
        gate_nxt = EV_ANGLE;
      end
    end else if (pos_active) begin
      if (pos_fire) begin
        gate_nxt = EV_POSITION;
      end
    end else begin
      // both inside their dead bands: replay
      gate_nxt = EV_NONE;
    end
  end

  // Replay the held command when no event fires
  assign cmd_nxt = (gate_nxt != EV_NONE) ? cmd_new : held_cmd_r;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_position_r      <= GAIN_POSITION_RST;
      gain_velocity_r      <= GAIN_VELOCITY_RST;
      gain_angle_r         <= GAIN_ANGLE_RST;
      gain_angular_rate_r  <= GAIN_ANGULAR_RATE_RST;
      ratio_threshold_r    <= RATIO_THRESHOLD_RST;
      angle_dead_band_r    <= '0;
      position_dead_band_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GAIN_POSITION:      gain_position_r      <= cfg_data;
        REG_GAIN_VELOCITY:      gain_velocity_r      <= cfg_data;
        REG_GAIN_ANGLE:         gain_angle_r         <= cfg_data;
        REG_GAIN_ANGULAR_RATE:  gain_angular_rate_r  <= cfg_data;
        REG_RATIO_THRESHOLD:    ratio_threshold_r    <= cfg_data;
        REG_ANGLE_DEAD_BAND:    angle_dead_band_r    <= cfg_data[BAND_W-1:0];
        REG_POSITION_DEAD_BAND: position_dead_band_r <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      angle_last_mag_r    <= LAST_MAG_RST;
      position_last_mag_r <= LAST_MAG_RST;
      held_cmd_r          <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        held_cmd_r <= cmd_nxt;
        if (gate_nxt == EV_ANGLE) begin
          angle_last_mag_r <= DATA_W'(angle_mag);
        end
        if (gate_nxt == EV_POSITION) begin
          position_last_mag_r <= DATA_W'(pos_mag);
        end
      end
    end
  end

  // Payload registers: load on acceptance, hold while stalled
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_position_r     <= in_position;
      s1_velocity_r     <= in_velocity;
      s1_angle_r        <= in_angle;
      s1_angular_rate_r <= in_angular_rate;
      s1_target_r       <= in_target_position;
    end
    if (s1_move) begin
      out_command_r <= cmd_nxt;
      out_event_r   <= gate_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_command    = out_command_r;
  assign out_gate_event = out_event_r;

`ifndef SYNTHESIS
  a_cmd_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_command_r <= CMD_LIMIT) && (out_command_r >= -CMD_LIMIT))
    else $error("command outside clip range");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_event_r == EV_NONE) || (out_event_r == EV_ANGLE) ||
                    (out_event_r == EV_POSITION))
    else $error("undefined gate event code");

  a_hold_on_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && (gate_nxt == EV_NONE)) |=> $stable(held_cmd_r))
    else $error("held command changed without an event");

  a_last_mag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (angle_last_mag_r != '0) && (position_last_mag_r != '0))
    else $error("stored magnitude reached zero");

  a_ready_only_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full, stalled pipeline");
`endif

endmodule

>>> dv/lqr_command_pkg.sv
// Scoreboard class for the event-gated controller: gate and feedback predictor, result queue.
`timescale 1ns / 1ps
package lqr_command_pkg;
  import eglqr_pkg::*;

  typedef struct packed {
    logic signed [15:0] position;
    logic signed [15:0] velocity;
    logic signed [15:0] angle;
    logic signed [15:0] angular_rate;
    logic signed [15:0] target;
  } sensor_t;

  typedef struct packed {
    logic signed [15:0] command;
    gate_ev_t           ev;
  } command_beat_t;

  class command_scoreboard;
    logic signed [15:0] gain_pos;
    logic signed [15:0] gain_vel;
    logic signed [15:0] gain_ang;
    logic signed [15:0] gain_rate;
    logic [15:0]        ratio;
    logic [14:0]        angle_band;
    logic [14:0]        pos_band;
    int unsigned        angle_mag;
    int unsigned        pos_mag;
    logic signed [15:0] held_command;
    command_beat_t      expected_commands[$];
    int unsigned        mismatches;
    int unsigned        beats_checked;
    int unsigned        angle_events;
    int unsigned        position_events;

    function new();
      gain_pos        = GAIN_POSITION_RST;
      gain_vel        = GAIN_VELOCITY_RST;
      gain_ang        = GAIN_ANGLE_RST;
      gain_rate       = GAIN_ANGULAR_RATE_RST;
      ratio           = RATIO_THRESHOLD_RST;
      angle_band      = '0;
      pos_band        = '0;
      angle_mag       = LAST_MAG_RST;
      pos_mag         = LAST_MAG_RST;
      held_command    = '0;
      mismatches      = 0;
      beats_checked   = 0;
      angle_events    = 0;
      position_events = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [15:0] data);
      case (idx)
        REG_GAIN_POSITION:      gain_pos   = data;
        REG_GAIN_VELOCITY:      gain_vel   = data;
        REG_GAIN_ANGLE:         gain_ang   = data;
        REG_GAIN_ANGULAR_RATE:  gain_rate  = data;
        REG_RATIO_THRESHOLD:    ratio      = data;
        REG_ANGLE_DEAD_BAND:    angle_band = data[14:0];
        REG_POSITION_DEAD_BAND: pos_band   = data[14:0];
        default: ;
      endcase
    endfunction

    // Exact log-ratio test by cross-multiplication, both directions.
    function bit ratio_trips(int unsigned cur, int unsigned last);
      longint unsigned c;
      longint unsigned l;
      longint unsigned r;
      c = cur;
      l = last;
      r = ratio;
      return (c * 16384 >= r * l) || (l * 16384 >= r * c);
    endfunction

    // Negated Q.18 sum, rounded half up to Q1.14, clipped to unity.
    function logic signed [15:0] feedback_law(int err, sensor_t s);
      longint acc;
      longint q;
      acc = -(longint'(gain_pos) * longint'(err)
            + longint'(gain_vel) * longint'(s.velocity)
            + longint'(gain_ang) * longint'(s.angle)
            + longint'(gain_rate) * longint'(s.angular_rate));
      q = (acc + 64'sd8) >>> 4;
      if (q > 16384) q = 16384;
      if (q < -16384) q = -16384;
      return q[15:0];
    endfunction

    function void note_sample(sensor_t s);
      int            err;
      int unsigned   amag;
      int unsigned   pmag;
      command_beat_t b;
      err = int'(s.position) - int'(s.target);
      if (err > 32767) err = 32767;
      if (err < -32768) err = -32768;
      amag = (s.angle < 0) ? -int'(s.angle) : int'(s.angle);
      pmag = (err < 0) ? -err : err;
      b.ev = EV_NONE;
      // angle gate first; position only when angle sits in its dead band
      if (amag > angle_band) begin
        if (ratio_trips(amag, angle_mag)) begin
          angle_mag = amag;
          b.ev = EV_ANGLE;
        end
      end else if (pmag > pos_band) begin
        if (ratio_trips(pmag, pos_mag)) begin
          pos_mag = pmag;
          b.ev = EV_POSITION;
        end
      end
      if (b.ev != EV_NONE) held_command = feedback_law(err, s);
      b.command = held_command;
      expected_commands.push_back(b);
    endfunction

    function void check_beat(logic signed [15:0] command, logic [1:0] ev);
      command_beat_t want;
      beats_checked++;
      if (expected_commands.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: command %0d gate %0d", command, ev);
        return;
      end
      want = expected_commands.pop_front();
      if (want.ev == EV_ANGLE) angle_events++;
      if (want.ev == EV_POSITION) position_events++;
      if (command !== want.command || ev !== want.ev) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on beat %0d: command %0d gate %0d, expected command %0d gate %0d",
                   beats_checked, command, ev, want.command, want.ev);
      end
    endfunction
  endclass

endpackage

>>> dv/event_gated_lqr_controller_tb.sv
// Self-checking testbench for the event-gated state-feedback controller.
`timescale 1ns / 1ps
module event_gated_lqr_controller_tb;
  import eglqr_pkg::*;
  import lqr_command_pkg::*;

  localparam int unsigned CYCLE_LIMIT       = 400000;
  localparam int unsigned DRAIN_CYCLES      = 4;
  localparam int unsigned ITEMS_PER_SETTING = 60;
  localparam int unsigned SETTING_COUNT     = 8;

  logic                       clk;
  logic                       rst_n              = 1'b0;
  logic                       in_valid           = 1'b0;
  logic                       in_ready;
  logic signed [DATA_W-1:0]   in_position        = '0;
  logic signed [DATA_W-1:0]   in_velocity        = '0;
  logic signed [DATA_W-1:0]   in_angle           = '0;
  logic signed [DATA_W-1:0]   in_angular_rate    = '0;
  logic signed [DATA_W-1:0]   in_target_position = '0;
  logic                       out_valid;
  logic                       out_ready          = 1'b0;
  logic signed [DATA_W-1:0]   out_command;
  logic [1:0]                 out_gate_event;
  logic                       cfg_we             = 1'b0;
  logic [IDX_W-1:0]           cfg_index          = '0;
  logic [DATA_W-1:0]          cfg_data           = '0;

  command_scoreboard board;
  int unsigned       burst_left  = 0;
  int unsigned       rx_left     = 0;
  int unsigned       cycle_count = 0;
  int unsigned       settings_run = 0;

  event_gated_lqr_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_position        (in_position),
    .in_velocity        (in_velocity),
    .in_angle           (in_angle),
    .in_angular_rate    (in_angular_rate),
    .in_target_position (in_target_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_command        (out_command),
    .out_gate_event     (out_gate_event),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run as a failure once the cycle limit is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: long runs of ready mixed with short and long stalls, so that
  // back-pressure lands on every pipeline phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_left   <= 0;
    end else if (rx_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_ready <= 1'b1;
          rx_left   <= $urandom_range(1, 40);
        end
        5, 6, 7: begin
          out_ready <= 1'b0;
          rx_left   <= $urandom_range(1, 4);
        end
        default: begin
          out_ready <= 1'b0;
          rx_left   <= $urandom_range(5, 20);
        end
      endcase
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  // Check every result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_beat(out_command, out_gate_event);
  end

  // Present one beat and hold it until accepted. Valid stays high between
  // beats of a burst; drop it only for a gap.
  task automatic send_sensor(sensor_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid           <= 1'b1;
    in_position        <= s.position;
    in_velocity        <= s.velocity;
    in_angle           <= s.angle;
    in_angular_rate    <= s.angular_rate;
    in_target_position <= s.target;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_sample(s);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe settle.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (board.expected_commands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_register(idx, data);
  endtask

  task automatic apply_setting(logic [15:0] gp, logic [15:0] gv, logic [15:0] ga,
                               logic [15:0] gr, logic [15:0] r, logic [15:0] ab,
                               logic [15:0] pb);
    write_register(REG_GAIN_POSITION, gp);
    write_register(REG_GAIN_VELOCITY, gv);
    write_register(REG_GAIN_ANGLE, ga);
    write_register(REG_GAIN_ANGULAR_RATE, gr);
    write_register(REG_RATIO_THRESHOLD, r);
    write_register(REG_ANGLE_DEAD_BAND, ab);
    write_register(REG_POSITION_DEAD_BAND, pb);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Magnitude just either side of the ratio threshold, up or down from last.
  function automatic longint near_edge(int unsigned last);
    longint m;
    if ($urandom_range(0, 1))
      m = longint'((longint'(last) * board.ratio + 16383) / 16384)
          - longint'($urandom_range(0, 1));
    else
      m = longint'((longint'(last) * 16384) / board.ratio) + longint'($urandom_range(0, 1));
    if (m < 0) m = 0;
    if (m > 32768) m = 32768;
    return m;
  endfunction

  function automatic logic signed [15:0] with_sign(longint m);
    if (m >= 32768) return -16'sd32768;
    return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // Mix of full-range noise and items aimed at the gate edges: magnitudes
  // straddling the ratio threshold, angles held inside their dead band so the
  // position gate gets its turn, and small values around the bands.
  function automatic sensor_t pick_sensor();
    sensor_t     s;
    int unsigned pick;
    longint      e;
    s.position     = 16'($urandom());
    s.velocity     = 16'($urandom());
    s.angle        = 16'($urandom());
    s.angular_rate = 16'($urandom());
    s.target       = 16'($urandom());
    pick = $urandom_range(0, 9);
    if (pick >= 4 && pick < 6) begin
      s.angle = with_sign(near_edge(board.angle_mag));
    end else if (pick >= 6 && pick < 8) begin
      s.angle    = with_sign(longint'($urandom_range(0, board.angle_band)));
      s.target   = with_sign(longint'($urandom_range(0, 8192)));
      e          = near_edge(board.pos_mag);
      s.position = clamp16(longint'(s.target) + ($urandom_range(0, 1) ? e : -e));
    end else if (pick == 8) begin
      s.position     = with_sign(longint'($urandom_range(0, 64)));
      s.velocity     = with_sign(longint'($urandom_range(0, 64)));
      s.angle        = with_sign(longint'($urandom_range(0, 64)));
      s.angular_rate = with_sign(longint'($urandom_range(0, 64)));
      s.target       = with_sign(longint'($urandom_range(0, 64)));
    end else if (pick == 9) begin
      // both gates inside their dead bands: held command replayed
      s.angle    = with_sign(longint'($urandom_range(0, board.angle_band)));
      s.target   = with_sign(longint'($urandom_range(0, 8192)));
      s.position = clamp16(longint'(s.target)
                           + longint'(with_sign(longint'($urandom_range(0, board.pos_band)))));
    end
    return s;
  endfunction

  // Directed beats under reset settings: gate edges, saturation, clipping.
  task automatic run_directed();
    sensor_t plan[$];
    plan = '{
      '{0, 0, 0, 0, 0},                           // both gates in their bands
      '{0, 0, 1, 0, 0},                           // angle out of band, ratio too small
      '{0, 0, 2, 0, 0},                           // angle event
      '{0, 0, -2, 0, 0},                          // same magnitude, held
      '{0, 0, 3, 0, 0},                           // upward ratio event
      '{0, 0, -32768, -32768, 0},                 // extreme angle, positive clip
      '{0, 0, 32767, 32767, 0},                   // one LSB apart, held
      '{0, 0, 1, 0, 0},                           // downward ratio event
      '{0, 0, 0, 0, 0},
      '{5, 0, 0, 0, 0},                           // position event
      '{32767, 32767, 0, 0, -32768},              // error saturates high
      '{-32768, -32768, 0, -32768, 32767},        // error saturates low, held
      '{1, 0, 0, 0, 0},                           // downward position event
      '{-32768, -32768, 0, -32768, 32767},        // magnitude 32768, negative clip
      '{32767, 32767, 0, 32767, -32768},
      '{0, 32767, 32767, 32767, 0},
      '{-1, -1, -1, -1, -1},
      '{21845, -21846, 21845, -21846, 21845},
      '{-21846, 21845, -21846, 21845, -21846},
      '{100, -100, 0, 50, -100}
    };
    foreach (plan[i]) send_sensor(plan[i]);
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Registers left at their reset values for the directed beats.
    run_directed();
    drain();

    for (int k = 0; k < SETTING_COUNT; k++) begin
      case (k)
        0: apply_setting(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'd16384, 16'd0,
                         16'd0);
        1: apply_setting(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd65535, 16'd32767,
                         16'd32767);
        2: apply_setting(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'd12000, 16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)));
        6: apply_setting(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'd65535, 16'd0, 16'd0);
        7: apply_setting(GAIN_POSITION_RST, GAIN_VELOCITY_RST, GAIN_ANGLE_RST,
                         GAIN_ANGULAR_RATE_RST, RATIO_THRESHOLD_RST, 16'd0, 16'd0);
        default: apply_setting(16'($urandom()), 16'($urandom()), 16'($urandom()),
                               16'($urandom()),
                               16'($urandom_range(0, 1) ? $urandom_range(16384, 20000)
                                                        : $urandom_range(16384, 65535)),
                               16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)));
      endcase
      repeat (ITEMS_PER_SETTING) send_sensor(pick_sensor());
      drain();
    end

    $display("checked %0d result beats: %0d angle events, %0d position events",
             board.beats_checked, board.angle_events, board.position_events);
    $display("register settings applied: %0d, mismatches: %0d, beats still owed: %0d",
             settings_run, board.mismatches, board.expected_commands.size());
    if (board.mismatches == 0 && board.expected_commands.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
